// ===== sv/signed_int_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text converter
// Shared forms for the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ITDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itda: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ITDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itda: next-cycle check failed");

`endif

// ===== sv/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Widths, character codes and the control group of the decimal digit cells.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int VALUE_WIDTH       = 32;
  localparam int CHAR_WIDTH        = 6;
  localparam int DIGIT_WIDTH       = 4;
  localparam int DIGIT_COUNT       = 10;
  localparam int INDEX_WIDTH       = $clog2(DIGIT_COUNT);
  localparam int SHIFT_COUNT_WIDTH = $clog2(VALUE_WIDTH);

  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO    = 6'd48;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS   = 6'd45;
  localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_WIDTH-1:0] DABBLE_BIAS  = 4'd3;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/itda_cell.sv =====
// ----------------------------------------------------------------------------
// itda_cell
// One decimal digit of the shift-and-add-three converter. Each shift corrects
// the digit, passes its top bit to the next cell up and takes the carry from
// the cell below.
// ----------------------------------------------------------------------------
module itda_cell (
  input  logic                                clk,
  input  itda_pkg::cell_ctrl_t                ctrl,
  input  logic                                carry_in,
  output logic                                carry_out,
  output logic [itda_pkg::DIGIT_WIDTH-1:0]    digit
);
  import itda_pkg::*;

  logic [DIGIT_WIDTH-1:0] adjusted;

  always_comb begin
    if (digit >= DABBLE_LIMIT) begin
      adjusted = digit + DABBLE_BIAS;
    end else begin
      adjusted = digit;
    end
  end

  assign carry_out = adjusted[DIGIT_WIDTH-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= {adjusted[DIGIT_WIDTH-2:0], carry_in};
    end
  end

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, one character
// per output request, most significant first, with the last one marked.
// ----------------------------------------------------------------------------
// A request is taken only while the converter is idle. The magnitude is then
// shifted one bit per cycle into a row of ten decimal digit cells; a scan state
// then finds the leading digit, and after that one character leaves per cycle
// while the output is not stalled: the minus sign for a negative value, then
// the digits without leading zeros. The converter takes no new request until
// the last character of an item has been loaded, since the magnitude is shifted
// bit-serially through the digit cells. The final character sits in the output
// register while the next request is already being taken.
module signed_int_to_decimal_ascii (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic signed [itda_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   char_valid,
  input  logic                                   char_stall,
  output logic [itda_pkg::CHAR_WIDTH-1:0]        char_code,
  output logic                                   is_last
);
  import itda_pkg::*;

  `include "signed_int_to_decimal_ascii_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                   state;
  logic                         neg;
  logic [VALUE_WIDTH-1:0]       mag;
  logic [SHIFT_COUNT_WIDTH-1:0] shift_count;
  logic [INDEX_WIDTH-1:0]       idx;
  logic [INDEX_WIDTH-1:0]       lead;
  logic [DIGIT_WIDTH-1:0]       digits [DIGIT_COUNT];
  logic [DIGIT_COUNT:0]         carry;
  cell_ctrl_t                   cell_ctrl;
  logic                         accept;
  logic                         out_free;
  logic                         load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !char_valid || !char_stall;
  assign load      = out_free && ((state == S_SIGN) || (state == S_EMIT));

  assign cell_ctrl.clear = accept;
  assign cell_ctrl.shift = (state == S_CONV);
  assign carry[0]        = mag[VALUE_WIDTH-1];

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    itda_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .digit     (digits[g])
    );
  end

  always_comb begin
    lead = '0;
    for (int i = 1; i < DIGIT_COUNT; i++) begin
      if (digits[i] != '0) begin
        lead = INDEX_WIDTH'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      neg         <= 1'b0;
      shift_count <= '0;
      idx         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            neg         <= value[VALUE_WIDTH-1];
            shift_count <= '0;
            state       <= S_CONV;
          end
        end
        S_CONV: begin
          shift_count <= shift_count + 1'b1;
          if (shift_count == SHIFT_COUNT_WIDTH'(VALUE_WIDTH - 1)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx   <= lead;
          state <= neg ? S_SIGN : S_EMIT;
        end
        S_SIGN: begin
          if (out_free) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (value[VALUE_WIDTH-1]) begin
        mag <= '0 - unsigned'(value);
      end else begin
        mag <= unsigned'(value);
      end
    end else if (state == S_CONV) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (state == S_SIGN) begin
        char_code <= CHAR_MINUS;
        is_last   <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + CHAR_WIDTH'(digits[idx]);
        is_last   <= (idx == '0);
      end
    end
  end

  `ITDA_ASSERT_NEXT(a_accept_starts_conv, accept, state == S_CONV)
  `ITDA_ASSERT_NOW(a_no_digit_overflow, state == S_CONV, !carry[DIGIT_COUNT])
  `ITDA_ASSERT_NOW(a_sign_only_negative, state == S_SIGN, neg)
  `ITDA_ASSERT_NEXT(a_final_char_marked, load && (state == S_EMIT) && (idx == '0),
                    char_valid && is_last && (state == S_IDLE))

endmodule
